// ----- sv/olle_pkg.sv -----
// ----------------------------------------------------------------------------
// olle_pkg
// Shared types and constants for the ordered linked list engine.
// ----------------------------------------------------------------------------
package olle_pkg;

   localparam int ITEM_COUNT = 32;
   localparam int LIST_COUNT = 4;
   localparam int KEY_WIDTH  = 32;
   localparam int NODE_COUNT = ITEM_COUNT + LIST_COUNT;

   localparam int ITEM_W  = $clog2(ITEM_COUNT);
   localparam int LIST_W  = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
   localparam int NODE_W  = $clog2(NODE_COUNT);
   localparam int COUNT_W = $clog2(ITEM_COUNT + 1);
   localparam int OWNER_W = $clog2(LIST_COUNT + 1);

   // operation codes
   localparam logic [1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [1:0] FUNC_INS_CUR = 2'd1;
   localparam logic [1:0] FUNC_INS_ORD = 2'd2;
   localparam logic [1:0] FUNC_REMOVE  = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_OWNED   = 2'd1;
   localparam logic [1:0] STAT_UNOWNED = 2'd2;

   typedef logic [NODE_W-1:0] node_type;

   // sentinel node of a list
   function automatic node_type sentinel(input logic [LIST_W-1:0] l);
      sentinel = node_type'(ITEM_COUNT) + node_type'(l);
   endfunction

endpackage

// ----- sv/ordered_linked_list_engine_top.sv -----
// A clear sweeps every item's owner before it reports; an ordered insert walks the
// links from the sentinel until a key compare, the sentinel or the walk bound ends it.
// Throughput: one item at a time; the next item is taken once the result has left.
// Reset clears control state at once; the sentinel links are then written by an
// init pass during which no item is accepted.
// ----------------------------------------------------------------------------
// ordered_linked_list_engine_top
// Sequencer over link, key and owner memories keeping circular lists, in key order or after a cursor.
// ----------------------------------------------------------------------------
module ordered_linked_list_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[1:0], list_id[3:2], item_id[8:4], order_value[40:9], zero[47:41]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], list_count[7:2], first_item[12:8], first_valid[13], zero[15:14]
   output logic [15:0] rsp_tdata
);

   localparam int NW = olle_pkg::NODE_W;
   localparam int IW = olle_pkg::ITEM_W;
   localparam int LW = olle_pkg::LIST_W;
   localparam int CW = olle_pkg::COUNT_W;
   localparam int OW = olle_pkg::OWNER_W;
   localparam int KW = olle_pkg::KEY_WIDTH;

   localparam logic [3:0] ST_INIT  = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_SWEEP = 4'd2;
   localparam logic [3:0] ST_RDAT  = 4'd3; // read next of anchor
   localparam logic [3:0] ST_WNX   = 4'd4; // wait next data
   localparam logic [3:0] ST_WKEY  = 4'd5; // compare key of candidate
   localparam logic [3:0] ST_SPL   = 4'd6; // write item links
   localparam logic [3:0] ST_SPL2  = 4'd7; // write neighbor links
   localparam logic [3:0] ST_RMRD  = 4'd8;
   localparam logic [3:0] ST_RMWT  = 4'd9;
   localparam logic [3:0] ST_RMWR  = 4'd10;
   localparam logic [3:0] ST_RPT   = 4'd11;
   localparam logic [3:0] ST_RPTW  = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;

   // storage
   logic [NW-1:0] next_mem  [olle_pkg::NODE_COUNT];
   logic [NW-1:0] prev_mem  [olle_pkg::NODE_COUNT];
   logic [KW-1:0] key_mem   [olle_pkg::ITEM_COUNT];
   logic [OW-1:0] owner_mem [olle_pkg::ITEM_COUNT];
   logic [NW-1:0] cursor_ff [olle_pkg::LIST_COUNT];
   logic [CW-1:0] size_ff   [olle_pkg::LIST_COUNT];

   logic [3:0]    state_ff, state_in;
   logic [1:0]    func_ff;
   logic [LW-1:0] list_ff;
   logic [IW-1:0] item_ff;
   logic [KW-1:0] key_ff;
   logic [NW-1:0] at_ff, nx_ff, pv_ff;
   logic [IW:0]   cnt_ff;
   logic [1:0]    stat_ff;
   logic [LW-1:0] rlist_ff;
   logic          out_v_ff;
   logic [15:0]   out_d_ff;

   // memory read ports (registered)
   logic [NW-1:0] nrd_addr, nrd_q, prd_addr, prd_q;
   logic [IW-1:0] krd_addr, ord_addr;
   logic [KW-1:0] krd_q;
   logic [OW-1:0] ord_q;

   // write controls
   logic          nwe, pwe, owe, kwe;
   logic [NW-1:0] nwa, nwd, pwa, pwd;
   logic [IW-1:0] owa;
   logic [OW-1:0] owd;

   logic [1:0]    r_func;
   logic [LW-1:0] r_list;
   logic [IW-1:0] r_item;
   logic          acc;

   assign r_func = req_tdata[1:0];
   assign r_list = LW'(req_tdata[3:2] % olle_pkg::LIST_COUNT);
   assign r_item = IW'(req_tdata[8:4] % olle_pkg::ITEM_COUNT);
   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;
   assign acc = req_tvalid && req_tready;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   always_ff @(posedge clock) begin
      nrd_q <= next_mem[nrd_addr];
      prd_q <= prev_mem[prd_addr];
      krd_q <= key_mem[krd_addr];
      ord_q <= owner_mem[ord_addr];
      if (nwe) next_mem[nwa] <= nwd;
      if (pwe) prev_mem[pwa] <= pwd;
      if (kwe) key_mem[item_ff] <= key_ff;
      if (owe) owner_mem[owa] <= owd;
   end

   // owner memory needs reset clearing: valid bits per item
   logic [olle_pkg::ITEM_COUNT-1:0] own_v_ff, own_v_in;
   logic [OW-1:0] own_rd;
   logic          own_rv_ff;
   assign own_rd = own_rv_ff ? ord_q : '0;

   // sequencer
   always_comb begin
      state_in = state_ff;
      nrd_addr = at_ff; prd_addr = at_ff;
      krd_addr = nx_ff[IW-1:0];
      ord_addr = item_ff;
      nwe = 1'b0; pwe = 1'b0; owe = 1'b0; kwe = 1'b0;
      nwa = at_ff; nwd = at_ff; pwa = at_ff; pwd = at_ff;
      owa = item_ff; owd = '0;
      own_v_in = own_v_ff;
      case (state_ff)
         ST_INIT: begin
            nwe = 1'b1; pwe = 1'b1;
            nwa = olle_pkg::sentinel(cnt_ff[LW-1:0]); nwd = nwa;
            pwa = nwa; pwd = nwa;
            if (cnt_ff == (IW+1)'(olle_pkg::LIST_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            ord_addr = r_item;
            if (acc) begin
               if (r_func == olle_pkg::FUNC_CLEAR) state_in = ST_SWEEP;
               else if (r_func == olle_pkg::FUNC_REMOVE) state_in = ST_RMRD;
               else state_in = ST_RDAT;
            end
         end
         ST_SWEEP: begin
            // reset list links, then clear owned items one per cycle
            ord_addr = cnt_ff[IW-1:0];
            if (cnt_ff == '0) begin
               nwe = 1'b1; pwe = 1'b1;
               nwa = olle_pkg::sentinel(list_ff); nwd = nwa; pwa = nwa; pwd = nwa;
            end
            if (cnt_ff != '0 && own_rd == OW'(list_ff) + OW'(1))
               own_v_in[cnt_ff[IW-1:0] - IW'(1)] = 1'b0;
            if (cnt_ff == (IW+1)'(olle_pkg::ITEM_COUNT)) state_in = ST_RPT;
         end
         ST_RDAT: begin
            // owner of item is valid now
            if (own_rd != '0) state_in = ST_RPT;
            else begin
               kwe = 1'b1;
               nrd_addr = at_ff;
               state_in = (func_ff == olle_pkg::FUNC_INS_CUR) ? ST_SPL : ST_WNX;
            end
         end
         ST_WNX: begin
            // nrd_q = next of at; fetch its key
            krd_addr = nrd_q[IW-1:0];
            if (nrd_q == olle_pkg::sentinel(list_ff) ||
                nrd_q >= NW'(olle_pkg::ITEM_COUNT) ||
                cnt_ff == (IW+1)'(olle_pkg::ITEM_COUNT))
               state_in = ST_SPL;
            else state_in = ST_WKEY;
         end
         ST_WKEY: begin
            nrd_addr = nx_ff;
            if (key_ff < krd_q) state_in = ST_WNX;
            else begin
               nrd_addr = at_ff;
               state_in = ST_SPL;
            end
         end
         ST_SPL: begin
            // nrd_q = next of at
            nwe = 1'b1; nwa = NW'(item_ff); nwd = nrd_q;
            pwe = 1'b1; pwa = NW'(item_ff); pwd = at_ff;
            owe = 1'b1; owd = OW'(list_ff) + OW'(1);
            own_v_in[item_ff] = 1'b1;
            state_in = ST_SPL2;
         end
         ST_SPL2: begin
            nwe = 1'b1; nwa = at_ff; nwd = NW'(item_ff);
            pwe = 1'b1; pwa = nx_ff; pwd = NW'(item_ff);
            state_in = ST_RPT;
         end
         ST_RMRD: begin
            nrd_addr = NW'(item_ff); prd_addr = NW'(item_ff);
            if (own_rd == '0 || own_rd > OW'(olle_pkg::LIST_COUNT)) state_in = ST_RPT;
            else state_in = ST_RMWT;
         end
         ST_RMWT: state_in = ST_RMWR;
         ST_RMWR: begin
            nwe = 1'b1; nwa = pv_ff; nwd = nx_ff;
            pwe = 1'b1; pwa = nx_ff; pwd = pv_ff;
            own_v_in[item_ff] = 1'b0;
            state_in = ST_RPT;
         end
         ST_RPT: begin
            nrd_addr = olle_pkg::sentinel(rlist_ff);
            state_in = ST_RPTW;
         end
         ST_RPTW: begin
            // keep the sentinel's next on the read port for the result
            nrd_addr = olle_pkg::sentinel(rlist_ff);
            state_in = ST_OUT;
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         cnt_ff   <= '0;
         own_v_ff <= '0;
         out_v_ff <= 1'b0;
         rlist_ff <= '0;
         for (int l = 0; l < olle_pkg::LIST_COUNT; l++) begin
            cursor_ff[l] <= olle_pkg::sentinel(LW'(l));
            size_ff[l]   <= '0;
         end
      end else begin
         state_ff  <= state_in;
         own_v_ff  <= own_v_in;
         own_rv_ff <= own_v_ff[ord_addr];
         if (out_v_ff && rsp_tready) out_v_ff <= 1'b0;
         case (state_ff)
            ST_INIT: cnt_ff <= cnt_ff + 1'b1;
            ST_IDLE: begin
               cnt_ff   <= '0;
               func_ff  <= r_func;
               list_ff  <= r_list;
               rlist_ff <= r_list;
               item_ff  <= r_item;
               key_ff   <= KW'(req_tdata[40:9]);
               stat_ff  <= olle_pkg::STAT_OK;
               at_ff    <= (r_func == olle_pkg::FUNC_INS_CUR) ? cursor_ff[r_list]
                                                              : olle_pkg::sentinel(r_list);
            end
            ST_SWEEP: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == '0) begin
                  size_ff[list_ff]   <= '0;
                  cursor_ff[list_ff] <= olle_pkg::sentinel(list_ff);
               end
            end
            ST_RDAT: if (own_rd != '0) stat_ff <= olle_pkg::STAT_OWNED;
            ST_WNX: nx_ff <= nrd_q;
            ST_WKEY: if (key_ff < krd_q) begin
               at_ff  <= nx_ff;
               cnt_ff <= cnt_ff + 1'b1;
            end
            ST_SPL: begin
               nx_ff <= nrd_q;
               size_ff[list_ff] <= size_ff[list_ff] + 1'b1;
               if (func_ff == olle_pkg::FUNC_INS_CUR) cursor_ff[list_ff] <= NW'(item_ff);
            end
            ST_RMRD: begin
               if (own_rd == '0 || own_rd > OW'(olle_pkg::LIST_COUNT))
                  stat_ff <= olle_pkg::STAT_UNOWNED;
               else rlist_ff <= LW'(own_rd - OW'(1));
            end
            ST_RMWT: begin
               nx_ff <= nrd_q;
               pv_ff <= prd_q;
            end
            ST_RMWR: begin
               if (cursor_ff[rlist_ff] == NW'(item_ff)) cursor_ff[rlist_ff] <= pv_ff;
               if (size_ff[rlist_ff] != '0) size_ff[rlist_ff] <= size_ff[rlist_ff] - 1'b1;
            end
            ST_OUT: begin
               out_v_ff <= 1'b1;
               out_d_ff <= {2'b00,
                            nrd_q != olle_pkg::sentinel(rlist_ff),
                            (nrd_q != olle_pkg::sentinel(rlist_ff)) ? nrd_q[4:0] : 5'd0,
                            size_ff[rlist_ff], stat_ff};
            end
            default: ;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("accept while busy");
   a_out_after_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |=> rsp_tvalid) else $error("result missing");
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff[rlist_ff] <= CW'(olle_pkg::ITEM_COUNT)) else $error("list size overflow");
`endif

endmodule
